// File: design/tle_pkg.sv
// Shared types and constants of the terminal line editor.
`default_nettype none
package tle_pkg;

  // Received byte codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_UP    = 8'h41;
  localparam logic [7:0] CH_DOWN  = 8'h42;
  localparam logic [7:0] CH_RIGHT = 8'h43;
  localparam logic [7:0] CH_LEFT  = 8'h44;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_FF    = 8'hFF;

  // Result kinds
  localparam logic [2:0] KIND_IGNORED   = 3'd0;
  localparam logic [2:0] KIND_INSERTED  = 3'd1;
  localparam logic [2:0] KIND_ERASED    = 3'd2;
  localparam logic [2:0] KIND_LEFT      = 3'd3;
  localparam logic [2:0] KIND_RIGHT     = 3'd4;
  localparam logic [2:0] KIND_RECALLED  = 3'd5;
  localparam logic [2:0] KIND_COMMITTED = 3'd6;

  // Configuration register indexes
  localparam logic REG_ECHO_ENABLE = 1'b0;

  typedef enum logic [1:0] {
    ESC_NORMAL = 2'd0,
    ESC_SPEC   = 2'd1,
    ESC_FUNC   = 2'd2
  } esc_t;

  typedef enum logic [2:0] {
    ACT_IGNORE,
    ACT_INSERT,
    ACT_ERASE,
    ACT_LEFT,
    ACT_RIGHT,
    ACT_RECALL,
    ACT_COMMIT
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SH_RD,
    ST_SH_WR,
    ST_RD1,
    ST_EMIT,
    ST_RCL_RD,
    ST_RCL_EMIT,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_DECIDE,
    ST_CMT_RD,
    ST_CMT_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic decode;
    logic sh_read;
    logic sh_write;
    logic rd_single;
    logic emit_single;
    logic rcl_read;
    logic rcl_emit;
    logic cmp_read;
    logic cmp_check;
    logic decide;
    logic cmt_read;
    logic cmt_emit;
  } dp_cmd_t;

  typedef struct packed {
    act_t act;
    logic need_cmp;
    logic rcl_empty;
    logic cmt_empty;
    logic shift_more;
    logic k_last;
    logic cmp_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: design/tle_if.sv
// Input and result channel interfaces of the terminal line editor.
`default_nettype none
interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] byte_value;
  logic [4:0] byte_index;
  logic [4:0] line_length;
  logic [4:0] cursor_pos;
  logic       show;
  logic       last;
  modport source(output valid, output event_kind, output byte_value, output byte_index,
                 output line_length, output cursor_pos, output show, output last,
                 input ready);
  modport sink(input valid, input event_kind, input byte_value, input byte_index,
               input line_length, input cursor_pos, input show, input last,
               output ready);
endinterface
`default_nettype wire

// File: design/tle_ctrl.sv
// Controller state machine of the terminal line editor.
`default_nettype none
module tle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tle_pkg::dp_status_t status,
  output tle_pkg::dp_cmd_t    cmd
);

  tle_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      tle_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = tle_pkg::ST_DECODE;
        end
      end
      tle_pkg::ST_DECODE: begin
        cmd.decode = 1'b1;
        case (status.act)
          tle_pkg::ACT_INSERT, tle_pkg::ACT_ERASE: state_nxt = tle_pkg::ST_SH_RD;
          tle_pkg::ACT_LEFT, tle_pkg::ACT_RIGHT:   state_nxt = tle_pkg::ST_RD1;
          tle_pkg::ACT_RECALL:
            state_nxt = status.rcl_empty ? tle_pkg::ST_EMIT : tle_pkg::ST_RCL_RD;
          tle_pkg::ACT_COMMIT: begin
            if (status.cmt_empty) begin
              state_nxt = tle_pkg::ST_EMIT;
            end else if (status.need_cmp) begin
              state_nxt = tle_pkg::ST_CMP_RD;
            end else begin
              state_nxt = tle_pkg::ST_DECIDE;
            end
          end
          default: state_nxt = tle_pkg::ST_EMIT;
        endcase
      end
      tle_pkg::ST_SH_RD: begin
        if (status.shift_more) begin
          cmd.sh_read = 1'b1;
          state_nxt   = tle_pkg::ST_SH_WR;
        end else begin
          state_nxt = tle_pkg::ST_EMIT;
        end
      end
      tle_pkg::ST_SH_WR: begin
        cmd.sh_write = 1'b1;
        state_nxt    = tle_pkg::ST_SH_RD;
      end
      tle_pkg::ST_RD1: begin
        cmd.rd_single = 1'b1;
        state_nxt     = tle_pkg::ST_EMIT;
      end
      tle_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_single = 1'b1;
          state_nxt       = tle_pkg::ST_IDLE;
        end
      end
      tle_pkg::ST_RCL_RD: begin
        cmd.rcl_read = 1'b1;
        state_nxt    = tle_pkg::ST_RCL_EMIT;
      end
      tle_pkg::ST_RCL_EMIT: begin
        if (status.out_free) begin
          cmd.rcl_emit = 1'b1;
          state_nxt    = status.k_last ? tle_pkg::ST_IDLE : tle_pkg::ST_RCL_RD;
        end
      end
      tle_pkg::ST_CMP_RD: begin
        cmd.cmp_read = 1'b1;
        state_nxt    = tle_pkg::ST_CMP_CHK;
      end
      tle_pkg::ST_CMP_CHK: begin
        cmd.cmp_check = 1'b1;
        state_nxt     = status.cmp_done ? tle_pkg::ST_DECIDE : tle_pkg::ST_CMP_RD;
      end
      tle_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = tle_pkg::ST_CMT_RD;
      end
      tle_pkg::ST_CMT_RD: begin
        cmd.cmt_read = 1'b1;
        state_nxt    = tle_pkg::ST_CMT_EMIT;
      end
      tle_pkg::ST_CMT_EMIT: begin
        if (status.out_free) begin
          cmd.cmt_emit = 1'b1;
          state_nxt    = status.k_last ? tle_pkg::ST_IDLE : tle_pkg::ST_CMT_RD;
        end
      end
      default: state_nxt = tle_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: design/tle_datapath.sv
// Datapath of the terminal line editor: edit line, history, decode and result register.
`default_nettype none
module tle_datapath #(
  parameter int LINE_SIZE     = 32,
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_byte,
  input  logic                echo_enable,
  input  tle_pkg::dp_cmd_t    cmd,
  output tle_pkg::dp_status_t status,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [2:0]          out_kind,
  output logic [7:0]          out_byte,
  output logic [4:0]          out_index,
  output logic [4:0]          out_length,
  output logic [4:0]          out_cursor,
  output logic                out_show,
  output logic                out_last
);

  localparam int IW  = $clog2(LINE_SIZE);
  localparam int CW  = $clog2(HISTORY_DEPTH + 1);
  localparam int SW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HAW = $clog2(HISTORY_DEPTH * LINE_SIZE);

  logic [7:0] edit_mem [LINE_SIZE];
  logic [7:0] hist_mem [HISTORY_DEPTH * LINE_SIZE];

  logic [7:0]      byte_r;
  tle_pkg::esc_t   esc_r;
  tle_pkg::act_t   act_r;
  logic [IW-1:0]   len_r, cur_r, k_r, lim_r, idx_r;
  logic            dir_r, push_r, full_r;
  logic [CW-1:0]   hcount_r, hptr_r;
  logic [SW-1:0]   hbase_r, slot_r, tgt_r;
  logic [IW-1:0]   hlen_r [HISTORY_DEPTH];
  logic [7:0]      edit_rd_r, hist_rd_r;

  logic            out_valid_r, out_show_r, out_last_r;
  logic [2:0]      out_kind_r;
  logic [7:0]      out_byte_r;
  logic [IW-1:0]   out_index_r, out_len_r, out_cur_r;

  // Map a history position (oldest first) onto a physical slot of the ring.
  function automatic logic [SW-1:0] phys(input logic [SW-1:0] base, input logic [CW-1:0] pos);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(pos);
    if (s >= (CW+1)'(HISTORY_DEPTH)) s = s - (CW+1)'(HISTORY_DEPTH);
    return SW'(s);
  endfunction

  // Decode of the held byte
  tle_pkg::act_t act;
  tle_pkg::esc_t esc_nxt;
  logic          normal;
  logic [CW-1:0] p_new, newest;
  logic [SW-1:0] rd_slot;
  logic [IW-1:0] rd_len;

  always_comb begin
    act     = tle_pkg::ACT_IGNORE;
    esc_nxt = tle_pkg::ESC_NORMAL;
    normal  = 1'b0;
    if (byte_r == tle_pkg::CH_ESC) begin
      esc_nxt = tle_pkg::ESC_SPEC;
    end else begin
      case (esc_r)
        tle_pkg::ESC_SPEC: begin
          if (byte_r == tle_pkg::CH_LBRK) esc_nxt = tle_pkg::ESC_FUNC;
          else normal = 1'b1;
        end
        tle_pkg::ESC_FUNC: begin
          case (byte_r)
            tle_pkg::CH_UP:    if (hptr_r != '0) act = tle_pkg::ACT_RECALL;
            tle_pkg::CH_DOWN:  if (hcount_r != '0) act = tle_pkg::ACT_RECALL;
            tle_pkg::CH_LEFT:  if (cur_r != '0) act = tle_pkg::ACT_LEFT;
            tle_pkg::CH_RIGHT: if (cur_r < len_r) act = tle_pkg::ACT_RIGHT;
            default:           normal = 1'b1;
          endcase
        end
        default: normal = 1'b1;
      endcase
    end
    if (normal) begin
      if (byte_r inside {tle_pkg::CH_NUL, tle_pkg::CH_FF, tle_pkg::CH_TAB}) begin
        act = tle_pkg::ACT_IGNORE;
      end else if (byte_r inside {tle_pkg::CH_DEL, tle_pkg::CH_BS}) begin
        act = (cur_r != '0) ? tle_pkg::ACT_ERASE : tle_pkg::ACT_IGNORE;
      end else if (byte_r inside {tle_pkg::CH_CR, tle_pkg::CH_LF}) begin
        act = tle_pkg::ACT_COMMIT;
      end else begin
        act = tle_pkg::ACT_INSERT;
      end
    end

    if (byte_r == tle_pkg::CH_UP) begin
      p_new = hptr_r - 1'b1;
    end else if ((CW+1)'(hptr_r) + 1'b1 < (CW+1)'(hcount_r)) begin
      p_new = hptr_r + 1'b1;
    end else begin
      p_new = hcount_r - 1'b1;
    end
    newest  = (hcount_r == '0) ? '0 : hcount_r - 1'b1;
    rd_slot = (act == tle_pkg::ACT_RECALL) ? phys(hbase_r, p_new) : phys(hbase_r, newest);
    rd_len  = hlen_r[rd_slot];
  end

  logic k_last, shift_more, bytes_equal;
  assign k_last      = (k_r == lim_r - 1'b1);
  assign shift_more  = dir_r ? (k_r > lim_r) : (k_r < lim_r);
  assign bytes_equal = (edit_rd_r == hist_rd_r);

  always_comb begin
    status            = '0;
    status.act        = act;
    status.need_cmp   = (hcount_r != '0) && (rd_len == len_r);
    status.rcl_empty  = (rd_len == '0);
    status.cmt_empty  = (len_r == '0);
    status.shift_more = shift_more;
    status.k_last     = k_last;
    status.cmp_done   = !bytes_equal || k_last;
    status.out_free   = !out_valid_r || out_ready;
  end

  // Memory port selection
  logic            edit_re, edit_we, hist_re, hist_we;
  logic [IW-1:0]   edit_raddr, edit_waddr;
  logic [7:0]      edit_wdata;
  logic [HAW-1:0]  hist_raddr, hist_waddr;

  always_comb begin
    edit_re    = cmd.sh_read | cmd.rd_single | cmd.cmp_read | cmd.cmt_read;
    edit_raddr = k_r;
    if (cmd.sh_read) edit_raddr = dir_r ? k_r - 1'b1 : k_r + 1'b1;
    edit_we    = cmd.sh_write | cmd.rcl_emit |
                 (cmd.emit_single && act_r == tle_pkg::ACT_INSERT);
    edit_waddr = cmd.emit_single ? idx_r : k_r;
    edit_wdata = cmd.emit_single ? byte_r : (cmd.rcl_emit ? hist_rd_r : edit_rd_r);
    hist_re    = cmd.rcl_read | cmd.cmp_read;
    hist_raddr = HAW'(slot_r) * HAW'(LINE_SIZE) + HAW'(k_r);
    hist_we    = cmd.cmt_emit & push_r;
    hist_waddr = HAW'(tgt_r) * HAW'(LINE_SIZE) + HAW'(k_r);
  end

  always_ff @(posedge clk) begin
    if (edit_we) edit_mem[edit_waddr] <= edit_wdata;
    if (edit_re) edit_rd_r <= edit_mem[edit_raddr];
    if (hist_we) hist_mem[hist_waddr] <= edit_rd_r;
    if (hist_re) hist_rd_r <= hist_mem[hist_raddr];
  end

  // Editor and history state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r    <= tle_pkg::ESC_NORMAL;
      act_r    <= tle_pkg::ACT_IGNORE;
      len_r    <= '0;
      cur_r    <= '0;
      hcount_r <= '0;
      hptr_r   <= '0;
      hbase_r  <= '0;
      push_r   <= 1'b0;
      full_r   <= 1'b0;
      dir_r    <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) hlen_r[i] <= '0;
    end else begin
      if (cmd.take) byte_r <= in_byte;
      if (cmd.decode) begin
        esc_r <= esc_nxt;
        act_r <= act;
        case (act)
          tle_pkg::ACT_INSERT: begin
            dir_r <= 1'b1;
            lim_r <= cur_r;
            idx_r <= cur_r;
            if (len_r == IW'(LINE_SIZE - 1)) begin
              // line full: discard it, no shift needed
              k_r   <= cur_r;
              len_r <= '0;
              cur_r <= '0;
            end else begin
              k_r   <= len_r;
              len_r <= len_r + 1'b1;
              cur_r <= cur_r + 1'b1;
            end
          end
          tle_pkg::ACT_ERASE: begin
            dir_r <= 1'b0;
            k_r   <= cur_r - 1'b1;
            lim_r <= len_r - 1'b1;
            idx_r <= cur_r - 1'b1;
            len_r <= len_r - 1'b1;
            cur_r <= cur_r - 1'b1;
          end
          tle_pkg::ACT_LEFT: begin
            k_r   <= cur_r - 1'b1;
            idx_r <= cur_r - 1'b1;
            cur_r <= cur_r - 1'b1;
          end
          tle_pkg::ACT_RIGHT: begin
            k_r   <= cur_r;
            idx_r <= cur_r;
            cur_r <= cur_r + 1'b1;
          end
          tle_pkg::ACT_RECALL: begin
            hptr_r <= p_new;
            slot_r <= rd_slot;
            len_r  <= rd_len;
            cur_r  <= rd_len;
            k_r    <= '0;
            lim_r  <= rd_len;
            idx_r  <= rd_len;
          end
          tle_pkg::ACT_COMMIT: begin
            hptr_r <= hcount_r;
            slot_r <= rd_slot;
            tgt_r  <= (hcount_r == CW'(HISTORY_DEPTH)) ? hbase_r : phys(hbase_r, hcount_r);
            full_r <= (hcount_r == CW'(HISTORY_DEPTH));
            push_r <= 1'b1;
            k_r    <= '0;
            lim_r  <= len_r;
            idx_r  <= '0;
            len_r  <= '0;
            cur_r  <= '0;
          end
          default: idx_r <= cur_r;
        endcase
      end
      if (cmd.sh_write) k_r <= dir_r ? k_r - 1'b1 : k_r + 1'b1;
      if (cmd.rcl_emit) k_r <= k_r + 1'b1;
      if (cmd.cmp_check && bytes_equal) begin
        if (k_last) push_r <= 1'b0;
        else k_r <= k_r + 1'b1;
      end
      if (cmd.decide) begin
        k_r <= '0;
        if (push_r) begin
          hlen_r[tgt_r] <= lim_r;
          if (full_r) begin
            hbase_r <= (hbase_r == SW'(HISTORY_DEPTH - 1)) ? '0 : hbase_r + 1'b1;
          end else begin
            hcount_r <= hcount_r + 1'b1;
            hptr_r   <= hcount_r + 1'b1;
          end
        end
      end
      if (cmd.cmt_emit) k_r <= k_r + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_single | cmd.rcl_emit | cmd.cmt_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    // Hold length and cursor with the result while the next byte is decoded
    if (cmd.emit_single | cmd.rcl_emit | cmd.cmt_emit) begin
      out_len_r <= len_r;
      out_cur_r <= cur_r;
    end
    if (cmd.emit_single) begin
      out_index_r <= idx_r;
      out_last_r  <= 1'b1;
      case (act_r)
        tle_pkg::ACT_INSERT: begin
          out_kind_r <= tle_pkg::KIND_INSERTED;
          out_byte_r <= byte_r;
          out_show_r <= echo_enable;
        end
        tle_pkg::ACT_ERASE: begin
          out_kind_r <= tle_pkg::KIND_ERASED;
          out_byte_r <= '0;
          out_show_r <= 1'b1;
        end
        tle_pkg::ACT_LEFT: begin
          out_kind_r <= tle_pkg::KIND_LEFT;
          out_byte_r <= edit_rd_r;
          out_show_r <= 1'b1;
        end
        tle_pkg::ACT_RIGHT: begin
          out_kind_r <= tle_pkg::KIND_RIGHT;
          out_byte_r <= edit_rd_r;
          out_show_r <= 1'b1;
        end
        default: begin
          out_kind_r <= tle_pkg::KIND_IGNORED;
          out_byte_r <= '0;
          out_show_r <= 1'b0;
        end
      endcase
    end else if (cmd.rcl_emit) begin
      out_kind_r  <= tle_pkg::KIND_RECALLED;
      out_byte_r  <= hist_rd_r;
      out_index_r <= k_r;
      out_show_r  <= 1'b1;
      out_last_r  <= k_last;
    end else if (cmd.cmt_emit) begin
      out_kind_r  <= tle_pkg::KIND_COMMITTED;
      out_byte_r  <= edit_rd_r;
      out_index_r <= k_r;
      out_show_r  <= echo_enable;
      out_last_r  <= k_last;
    end
  end

  // Fit positions to the 5-bit result fields
  logic [IW+4:0] idx_ext, len_ext, cur_ext;
  assign idx_ext = {5'b0, out_index_r};
  assign len_ext = {5'b0, out_len_r};
  assign cur_ext = {5'b0, out_cur_r};

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_byte   = out_byte_r;
  assign out_index  = idx_ext[4:0];
  assign out_length = len_ext[4:0];
  assign out_cursor = cur_ext[4:0];
  assign out_show   = out_show_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

// File: design/terminal_line_editor_with_history.sv
// Top level of the terminal line editor with command history.
// Takes one received byte per transaction and returns one or more result
// transactions, the final one flagged by last. Cursor moves, ignored bytes
// and escape prefixes are decoded and answered with a single result; an
// insert or backspace first moves each byte behind the cursor in the edit
// line with a read and a write; a recall reads and emits each byte of the
// recalled line and a line commit reads and emits each byte of the line,
// and a commit whose length matches the newest history entry first compares
// it byte by byte. These steps come from walking the single-port edit line
// and history memories one byte at a time with registered read data; result
// backpressure can stall them. A new byte is taken while the last result still waits to be taken.
// No clearing pass after reset. echo_enable lives at byte address 0.
`default_nettype none
module terminal_line_editor_with_history #(
  parameter int LINE_SIZE     = 32,
  parameter int HISTORY_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  tle_in_if.sink       in_chan,
  tle_out_if.source    out_chan,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  tle_pkg::dp_cmd_t    cmd;
  tle_pkg::dp_status_t status;
  logic                echo_r;
  logic                reg_hit;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[2] == tle_pkg::REG_ECHO_ENABLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_hit) begin
      echo_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = reg_hit ? {31'b0, echo_r} : 32'b0;

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tle_datapath #(
    .LINE_SIZE     (LINE_SIZE),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_byte     (in_chan.rx_byte),
    .echo_enable (echo_r),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_kind    (out_chan.event_kind),
    .out_byte    (out_chan.byte_value),
    .out_index   (out_chan.byte_index),
    .out_length  (out_chan.line_length),
    .out_cursor  (out_chan.cursor_pos),
    .out_show    (out_chan.show),
    .out_last    (out_chan.last)
  );

endmodule
`default_nettype wire
